// File: src/vtcc_pkg.sv
package vtcc_pkg;

  localparam int OUT_BITS       = 24;
  localparam int OUT_MAX        = 8388607;
  localparam int OUT_MIN        = -8388608;
  localparam int TRANS_BITS     = 21;
  localparam int ROW_BITS       = 48;
  localparam int TRANS_REG_BITS = 63;
  localparam int FLAG_BITS      = 6;
  localparam int CFG_DATA_BITS  = 63;
  localparam int CFG_INDEX_BITS = 3;

  // Frustum slope 1.1 taken as 1126/1024.
  localparam int SLOPE_NUM   = 1126;
  localparam int SLOPE_SHIFT = 10;

  localparam logic [ROW_BITS-1:0]       MATRIX_X_RESET = 48'd16384;
  localparam logic [ROW_BITS-1:0]       MATRIX_Y_RESET = 48'd1073741824;
  localparam logic [ROW_BITS-1:0]       MATRIX_Z_RESET = 48'd70368744177664;
  localparam logic [TRANS_REG_BITS-1:0] TRANS_RESET    = '0;
  localparam logic [OUT_BITS-1:0]       MIN_Z_RESET    = 24'd16;
  localparam logic [OUT_BITS-1:0]       MAX_Z_RESET    = 24'd8388607;

  localparam int FLAG_NEAR   = 0;
  localparam int FLAG_FAR    = 1;
  localparam int FLAG_LEFT   = 2;
  localparam int FLAG_RIGHT  = 3;
  localparam int FLAG_TOP    = 4;
  localparam int FLAG_BOTTOM = 5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MATRIX_X    = 3'd0,
    REG_MATRIX_Y    = 3'd1,
    REG_MATRIX_Z    = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_MIN_Z       = 3'd4,
    REG_MAX_Z       = 3'd5
  } cfg_reg_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAC   = 7'b0000010,
    ST_FIN   = 7'b0000100,
    ST_SLOPE = 7'b0001000,
    ST_CMPX  = 7'b0010000,
    ST_CMPY  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic en;
  } mul_ctrl_t;

endpackage

// File: src/vtcc_vtx_if.sv
interface vtcc_vtx_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;
  logic                         in_last;

  modport source (output valid, output in_x, output in_y, output in_z, output in_last,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_last,
                  output ready);
endinterface

// File: src/vtcc_res_if.sv
interface vtcc_res_if;
  import vtcc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] out_x;
  logic signed [OUT_BITS-1:0] out_y;
  logic signed [OUT_BITS-1:0] out_z;
  logic [FLAG_BITS-1:0]       clip_flags;
  logic                       list_visible;
  logic                       out_last;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output clip_flags, output list_visible, output out_last,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input clip_flags, input list_visible, input out_last,
                  output ready);
endinterface

// File: src/vtcc_mul.sv
module vtcc_mul #(
  parameter int A_BITS = 16,
  parameter int B_BITS = 24
) (
  input  logic                           clk,
  input  vtcc_pkg::mul_ctrl_t            ctrl,
  input  logic signed [A_BITS-1:0]       a,
  input  logic signed [B_BITS-1:0]       b,
  output logic signed [A_BITS+B_BITS-1:0] p
);
  import vtcc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      p <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
    end
  end

endmodule

// File: src/vertex_transform_clip_codes.sv
// Vertex transform with frustum clip codes.
// Vertices arrive on the vtx channel and each one gives exactly one result
// item on the res channel; both channels move an item when valid and ready
// are high at a rising clock edge. The result holds the rotated and
// translated coordinates, saturated to 24 bits, the six clip flags, and on
// the vertex marked last the visible bit of the whole list.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no vertex is in flight,
// and the block itself does not enforce it.
// One shared multiplier does all nine matrix products and the slope product.
// A vertex passes through multiply-accumulate, round and saturate of each
// row, the slope product, the X and Y compares and the output register
// load; no new vertex is accepted before the previous one leaves that load.
// The output register holds its item until the receiver takes it; the next
// vertex is accepted meanwhile, but its result waits in the last step.
// A synchronous reset restores the register defaults, empties the output
// register and restarts the list.
module vertex_transform_clip_codes #(
  parameter int COORD_BITS = 20,
  parameter int COEF_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  vtcc_vtx_if.sink                              vtx,
  vtcc_res_if.source                            res,
  input  logic                                  cfg_we,
  input  logic [vtcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [vtcc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import vtcc_pkg::*;

  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam int MA        = (COEF_BITS > 12) ? COEF_BITS : 12;
  localparam int MB        = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
  localparam int PW        = MA + MB;
  localparam int ACC_W     = PW + 2;
  localparam int CW        = PW + 1;
  localparam int ROW_EXT   = 3 * COEF_BITS;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC - 1);

  logic [ROW_BITS-1:0]       matrix_row_x;
  logic [ROW_BITS-1:0]       matrix_row_y;
  logic [ROW_BITS-1:0]       matrix_row_z;
  logic [TRANS_REG_BITS-1:0] translation;
  logic signed [OUT_BITS-1:0] min_z;
  logic signed [OUT_BITS-1:0] max_z;

  state_t state;

  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic                         last;

  logic [1:0] irow;
  logic [1:0] icol;
  logic       pvalid;
  logic       pcol2;
  logic [1:0] prow;
  logic [1:0] frow;

  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    sums [3];
  logic signed [OUT_BITS-1:0] vals [3];
  logic [FLAG_BITS-1:0]       flags;
  logic [FLAG_BITS-1:0]       flags_and;

  logic                       o_valid;
  logic signed [OUT_BITS-1:0] o_x;
  logic signed [OUT_BITS-1:0] o_y;
  logic signed [OUT_BITS-1:0] o_z;
  logic [FLAG_BITS-1:0]       o_flags;
  logic                       o_visible;
  logic                       o_last;

  mul_ctrl_t               mul_ctrl;
  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [PW-1:0]    prod;

  logic                    issue;
  logic [ROW_BITS-1:0]     row_sel;
  logic [ROW_EXT-1:0]      row_ext;
  logic [COEF_BITS-1:0]    coef;
  logic signed [COORD_BITS-1:0] coord;
  logic signed [ACC_W-1:0] prodx;

  logic signed [ACC_W-1:0]      shifted;
  logic signed [TRANS_BITS-1:0] trans_sel;
  logic signed [ACC_W:0]        fin_sum;
  logic signed [OUT_BITS-1:0]   fin_sat;

  logic signed [CW-1:0] s_pos;
  logic signed [CW-1:0] s_neg;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 near_hit;
  logic                 far_hit;
  logic [FLAG_BITS-1:0] flags_all;
  logic                 take;
  logic                 load_out;

  vtcc_mul #(.A_BITS(MA), .B_BITS(MB)) u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .a    (mul_a),
    .b    (mul_b),
    .p    (prod)
  );

  assign take     = vtx.valid && vtx.ready;
  assign issue    = (state == ST_MAC) && (irow != 2'd3);
  assign load_out = (state == ST_OUT) && (!o_valid || res.ready);

  always_comb begin
    unique case (irow)
      2'd0:    row_sel = matrix_row_x;
      2'd1:    row_sel = matrix_row_y;
      default: row_sel = matrix_row_z;
    endcase
    row_ext = ROW_EXT'(row_sel);
    unique case (icol)
      2'd0: begin
        coef  = row_ext[0 +: COEF_BITS];
        coord = cx;
      end
      2'd1: begin
        coef  = row_ext[COEF_BITS +: COEF_BITS];
        coord = cy;
      end
      default: begin
        coef  = row_ext[2*COEF_BITS +: COEF_BITS];
        coord = cz;
      end
    endcase

    mul_ctrl.en = issue || (state == ST_SLOPE);
    if (state == ST_SLOPE) begin
      mul_a = MA'(SLOPE_NUM);
      mul_b = MB'(vals[2]);
    end else begin
      mul_a = MA'($signed(coef));
      mul_b = MB'(coord);
    end
    prodx = ACC_W'(prod);
  end

  always_comb begin
    unique case (frow)
      2'd0: begin
        shifted   = sums[0] >>> COEF_FRAC;
        trans_sel = $signed(translation[0 +: TRANS_BITS]);
      end
      2'd1: begin
        shifted   = sums[1] >>> COEF_FRAC;
        trans_sel = $signed(translation[TRANS_BITS +: TRANS_BITS]);
      end
      default: begin
        shifted   = sums[2] >>> COEF_FRAC;
        trans_sel = $signed(translation[2*TRANS_BITS +: TRANS_BITS]);
      end
    endcase
    fin_sum = (ACC_W+1)'(shifted) + (ACC_W+1)'(trans_sel);
    if (fin_sum > (ACC_W+1)'(OUT_MAX)) begin
      fin_sat = OUT_BITS'(OUT_MAX);
    end else if (fin_sum < (ACC_W+1)'(OUT_MIN)) begin
      fin_sat = OUT_BITS'(OUT_MIN);
    end else begin
      fin_sat = fin_sum[OUT_BITS-1:0];
    end
  end

  always_comb begin
    s_pos     = CW'(prod);
    s_neg     = -s_pos;
    xs        = CW'(vals[0]) <<< SLOPE_SHIFT;
    ys        = CW'(vals[1]) <<< SLOPE_SHIFT;
    near_hit  = vals[2] < min_z;
    far_hit   = vals[2] > max_z;
    flags_all = flags_and & flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row_x <= MATRIX_X_RESET;
      matrix_row_y <= MATRIX_Y_RESET;
      matrix_row_z <= MATRIX_Z_RESET;
      translation  <= TRANS_RESET;
      min_z        <= MIN_Z_RESET;
      max_z        <= MAX_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATRIX_X:    matrix_row_x <= cfg_data[ROW_BITS-1:0];
        REG_MATRIX_Y:    matrix_row_y <= cfg_data[ROW_BITS-1:0];
        REG_MATRIX_Z:    matrix_row_z <= cfg_data[ROW_BITS-1:0];
        REG_TRANSLATION: translation  <= cfg_data[TRANS_REG_BITS-1:0];
        REG_MIN_Z:       min_z        <= cfg_data[OUT_BITS-1:0];
        REG_MAX_Z:       max_z        <= cfg_data[OUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flags_and <= '1;
      pvalid    <= 1'b0;
      irow      <= 2'd3;
      icol      <= 2'd0;
      frow      <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cx     <= vtx.in_x;
            cy     <= vtx.in_y;
            cz     <= vtx.in_z;
            last   <= vtx.in_last;
            irow   <= 2'd0;
            icol   <= 2'd0;
            pvalid <= 1'b0;
            acc    <= HALF;
            state  <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (issue) begin
            if (icol == 2'd2) begin
              icol <= 2'd0;
              irow <= irow + 2'd1;
            end else begin
              icol <= icol + 2'd1;
            end
          end
          pvalid <= issue;
          pcol2  <= (icol == 2'd2);
          prow   <= irow;
          if (pvalid) begin
            if (pcol2) begin
              sums[prow] <= acc + prodx;
              acc        <= HALF;
              if (prow == 2'd2) begin
                frow  <= 2'd0;
                state <= ST_FIN;
              end
            end else begin
              acc <= acc + prodx;
            end
          end
        end
        ST_FIN: begin
          vals[frow] <= fin_sat;
          if (frow == 2'd2) begin
            state <= ST_SLOPE;
          end else begin
            frow <= frow + 2'd1;
          end
        end
        ST_SLOPE: begin
          state <= ST_CMPX;
        end
        ST_CMPX: begin
          if (near_hit) begin
            flags <= FLAG_BITS'(1 << FLAG_NEAR);
          end else if (far_hit) begin
            flags <= FLAG_BITS'(1 << FLAG_FAR);
          end else if (xs > s_pos) begin
            flags <= FLAG_BITS'(1 << FLAG_RIGHT);
          end else if (xs < s_neg) begin
            flags <= FLAG_BITS'(1 << FLAG_LEFT);
          end else begin
            flags <= '0;
          end
          state <= ST_CMPY;
        end
        ST_CMPY: begin
          if (flags[FLAG_NEAR] == 1'b0 && flags[FLAG_FAR] == 1'b0) begin
            if (ys > s_pos) begin
              flags[FLAG_TOP] <= 1'b1;
            end else if (ys < s_neg) begin
              flags[FLAG_BOTTOM] <= 1'b1;
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (load_out) begin
            flags_and <= last ? '1 : flags_all;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_x       <= vals[0];
      o_y       <= vals[1];
      o_z       <= vals[2];
      o_flags   <= flags;
      o_visible <= last && (flags_all == '0);
      o_last    <= last;
    end
  end

  assign vtx.ready        = (state == ST_IDLE);
  assign res.valid        = o_valid;
  assign res.out_x        = o_x;
  assign res.out_y        = o_y;
  assign res.out_z        = o_z;
  assign res.clip_flags   = o_flags;
  assign res.list_visible = o_visible;
  assign res.out_last     = o_last;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !vtx.ready)
    else $error("vertex accepted while the previous one is in work");

  a_pairs_exclusive: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> !(o_flags[FLAG_LEFT] && o_flags[FLAG_RIGHT]) &&
                !(o_flags[FLAG_TOP] && o_flags[FLAG_BOTTOM]))
    else $error("opposite clip flags set together");

  a_depth_alone: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_flags[FLAG_NEAR] || o_flags[FLAG_FAR])) |->
      (o_flags[FLAG_LEFT] == 1'b0 && o_flags[FLAG_RIGHT] == 1'b0 &&
       o_flags[FLAG_TOP] == 1'b0 && o_flags[FLAG_BOTTOM] == 1'b0))
    else $error("lateral flag set on a vertex outside the depth range");

  a_visible_on_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_visible) |-> o_last)
    else $error("visible bit on a vertex that does not end the list");

  a_list_restart: assert property (@(posedge clk) disable iff (rst)
    (load_out && last) |=> (flags_and == '1))
    else $error("flag accumulator not restarted after the last vertex");

endmodule
